@@ design/sitrd_pkg.sv @@
`default_nettype none
package sitrd_pkg;

   localparam int DigitDepth = 32;
   localparam int MaxSymbols = 16;
   localparam int AddrW = $clog2(DigitDepth);
   localparam int CntW = $clog2(DigitDepth + 1);
   localparam int IdxW = 2;

   localparam logic [IdxW-1:0] RegAlphabetLow = 2'd0;
   localparam logic [IdxW-1:0] RegAlphabetHigh = 2'd1;
   localparam logic [IdxW-1:0] RegSymbolCount = 2'd2;

   localparam logic [63:0] ResetAlphabetLow = 64'd3978425819141910832;
   localparam logic [63:0] ResetAlphabetHigh = 64'd5063528411713059128;
   localparam logic [4:0] ResetSymbolCount = 5'd10;

   localparam logic [7:0] PlusChar = 8'h2B;
   localparam logic [7:0] MinusChar = 8'h2D;

   typedef struct packed {
      logic [63:0] alphabet_low;
      logic [63:0] alphabet_high;
      logic [4:0] symbol_count;
   } cfg_type;

   typedef struct packed {
      logic neg;
      logic [31:0] mag;
   } entry_type;

   function automatic logic [7:0] symbol_at(input cfg_type cfg, input logic [3:0] idx);
      logic [127:0] full;
      full = {cfg.alphabet_high, cfg.alphabet_low};
      return full[{idx, 3'b000} +: 8];
   endfunction

   // floor(2^32 / radix); estimate from it is the quotient or one below
   function automatic logic [31:0] recip(input logic [4:0] radix);
      logic [31:0] r;
      case (radix)
         5'd2: r = 32'h80000000;
         5'd3: r = 32'h55555555;
         5'd4: r = 32'h40000000;
         5'd5: r = 32'h33333333;
         5'd6: r = 32'h2AAAAAAA;
         5'd7: r = 32'h24924924;
         5'd8: r = 32'h20000000;
         5'd9: r = 32'h1C71C71C;
         5'd10: r = 32'h19999999;
         5'd11: r = 32'h1745D174;
         5'd12: r = 32'h15555555;
         5'd13: r = 32'h13B13B13;
         5'd14: r = 32'h12492492;
         5'd15: r = 32'h11111111;
         5'd16: r = 32'h10000000;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

@@ design/sitrd_ram.sv @@
`default_nettype none
module sitrd_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 32
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input wire logic [WIDTH-1:0] wr_data,
   input wire logic rd_en,
   input wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

@@ design/sitrd_front.sv @@
`default_nettype none
module sitrd_front (
   input wire sitrd_pkg::cfg_type cfg,
   input wire logic req_valid,
   input wire logic [31:0] req_value,
   output logic req_stall,
   input wire logic q_full,
   output logic q_push,
   output sitrd_pkg::entry_type q_entry
);

   logic ok;

   always_comb begin
      logic [7:0] sa;
      ok = (cfg.symbol_count >= 5'd2) && (cfg.symbol_count <= 5'(sitrd_pkg::MaxSymbols));
      for (int a = 0; a < 16; a++) begin
         sa = sitrd_pkg::symbol_at(cfg, 4'(a));
         if (5'(a) < cfg.symbol_count) begin
            if (sa == 8'h00 || sa == sitrd_pkg::PlusChar || sa == sitrd_pkg::MinusChar) begin
               ok = 1'b0;
            end
            for (int b = a + 1; b < 16; b++) begin
               if (5'(b) < cfg.symbol_count && sitrd_pkg::symbol_at(cfg, 4'(b)) == sa) begin
                  ok = 1'b0;
               end
            end
         end
      end
   end

   // items with a bad alphabet are taken and dropped
   assign req_stall = q_full;
   assign q_push = req_valid && !q_full && ok;
   assign q_entry.neg = req_value[31];
   assign q_entry.mag = req_value[31] ? (~req_value + 32'd1) : req_value;

endmodule
`default_nettype wire

@@ design/sitrd_queue.sv @@
`default_nettype none
module sitrd_queue (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   input wire sitrd_pkg::entry_type push_entry,
   output logic full,
   input wire logic pop,
   output logic empty,
   output sitrd_pkg::entry_type head
);

   sitrd_pkg::entry_type slot_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic do_push, do_pop;

   assign full = (fill_ff == 2'd2);
   assign empty = (fill_ff == 2'd0);
   assign head = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

@@ design/sitrd_back.sv @@
`default_nettype none
module sitrd_back (
   input wire logic clock,
   input wire logic reset,
   input wire sitrd_pkg::cfg_type cfg,
   input wire logic q_empty,
   input wire sitrd_pkg::entry_type q_head,
   output logic q_pop,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [7:0] rsp_char_out,
   output logic rsp_last
);

   typedef enum logic [2:0] {
      IDLE,
      MUL,
      DIV,
      SIGN,
      READ,
      SHOW
   } state_type;

   state_type state_ff, state_in;
   logic [31:0] mag_ff, mag_in;
   logic neg_ff, neg_in;
   logic [63:0] prod_ff, prod_in;
   logic [sitrd_pkg::CntW-1:0] cnt_ff, cnt_in;

   logic [31:0] q_est, qr, rem_raw, q_fix, rem_fix;
   logic [sitrd_pkg::CntW-1:0] cnt_dec;
   logic wr_en, rd_en, taken;
   logic [3:0] rd_digit;

   assign q_est = prod_ff[63:32];
   assign qr = 32'(q_est * 32'(cfg.symbol_count));
   assign rem_raw = mag_ff - qr;
   assign q_fix = (rem_raw >= 32'(cfg.symbol_count)) ? q_est + 32'd1 : q_est;
   assign rem_fix = (rem_raw >= 32'(cfg.symbol_count)) ?
                    rem_raw - 32'(cfg.symbol_count) : rem_raw;
   assign cnt_dec = cnt_ff - sitrd_pkg::CntW'(1);
   assign taken = rsp_valid && !rsp_stall;

   assign q_pop = (state_ff == IDLE) && !q_empty;
   assign wr_en = (state_ff == DIV);
   assign rd_en = (state_ff == READ);

   sitrd_ram #(
      .WIDTH(4),
      .DEPTH(sitrd_pkg::DigitDepth)
   ) u_digits (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(cnt_ff[sitrd_pkg::AddrW-1:0]),
      .wr_data(rem_fix[3:0]),
      .rd_en(rd_en),
      .rd_addr(cnt_dec[sitrd_pkg::AddrW-1:0]),
      .rd_data_ff(rd_digit)
   );

   assign rsp_valid = (state_ff == SIGN) || (state_ff == SHOW);
   assign rsp_char_out = (state_ff == SIGN) ? sitrd_pkg::MinusChar :
                         sitrd_pkg::symbol_at(cfg, rd_digit);
   assign rsp_last = (state_ff == SHOW) && (cnt_ff == sitrd_pkg::CntW'(1));

   always_comb begin
      state_in = state_ff;
      mag_in = mag_ff;
      neg_in = neg_ff;
      prod_in = prod_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         IDLE: begin
            if (!q_empty) begin
               mag_in = q_head.mag;
               neg_in = q_head.neg;
               cnt_in = '0;
               state_in = MUL;
            end
         end
         MUL: begin
            prod_in = 64'(mag_ff) * 64'(sitrd_pkg::recip(cfg.symbol_count));
            state_in = DIV;
         end
         DIV: begin
            // digit written at cnt_ff, least significant first
            mag_in = q_fix;
            cnt_in = cnt_ff + sitrd_pkg::CntW'(1);
            if (q_fix == 32'd0 || cnt_ff == sitrd_pkg::CntW'(sitrd_pkg::DigitDepth - 1)) begin
               state_in = neg_ff ? SIGN : READ;
            end else begin
               state_in = MUL;
            end
         end
         SIGN: begin
            if (taken) begin
               state_in = READ;
            end
         end
         READ: begin
            state_in = SHOW;
         end
         SHOW: begin
            if (taken) begin
               cnt_in = cnt_dec;
               state_in = (cnt_ff == sitrd_pkg::CntW'(1)) ? IDLE : READ;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      prod_ff <= prod_in;
   end

endmodule
`default_nettype wire

@@ design/signed_int_to_radix_digits.sv @@
// Path: an item passes the two-entry queue, then a multiply and a correction step per digit in
// the divide loop; the sign comes out first if there is one, then a read and a show step per digit byte.
// The front takes items while its two-entry queue has room, also while the back is still
// converting an earlier item.
// Reset (synchronous): control cleared, registers back to "0123456789ABCDEF" and radix
// 10; the digit store is not cleared.
`default_nettype none
module signed_int_to_radix_digits (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic signed [31:0] req_value,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [7:0] rsp_char_out,
   output logic rsp_last,
   input wire logic csr_write,
   input wire logic [sitrd_pkg::IdxW-1:0] csr_index,
   input wire logic [63:0] csr_data
);

   sitrd_pkg::cfg_type cfg_ff;
   sitrd_pkg::entry_type push_entry, head;
   logic push, full, pop, empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alphabet_low <= sitrd_pkg::ResetAlphabetLow;
         cfg_ff.alphabet_high <= sitrd_pkg::ResetAlphabetHigh;
         cfg_ff.symbol_count <= sitrd_pkg::ResetSymbolCount;
      end else if (csr_write) begin
         case (csr_index)
            sitrd_pkg::RegAlphabetLow: cfg_ff.alphabet_low <= csr_data;
            sitrd_pkg::RegAlphabetHigh: cfg_ff.alphabet_high <= csr_data;
            sitrd_pkg::RegSymbolCount: cfg_ff.symbol_count <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   sitrd_front u_front (
      .cfg(cfg_ff),
      .req_valid(req_valid),
      .req_value(req_value),
      .req_stall(req_stall),
      .q_full(full),
      .q_push(push),
      .q_entry(push_entry)
   );

   sitrd_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_entry(push_entry),
      .full(full),
      .pop(pop),
      .empty(empty),
      .head(head)
   );

   sitrd_back u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .q_empty(empty),
      .q_head(head),
      .q_pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_char_out(rsp_char_out),
      .rsp_last(rsp_last)
   );

endmodule
`default_nettype wire

@@ design/sitrd_checker.sv @@
`default_nettype none
module sitrd_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic [7:0] rsp_char_out,
   input wire logic rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_char_out) && $stable(rsp_last))
      else $error("stalled item changed or dropped");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("item shown right after reset");

   // the sign never ends a text
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_out == sitrd_pkg::MinusChar |-> !rsp_last)
      else $error("minus sign flagged as last");

   a_one_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_char_out == sitrd_pkg::MinusChar
      |=> !(rsp_valid && rsp_char_out == sitrd_pkg::MinusChar))
      else $error("two minus signs in a row");

endmodule

bind signed_int_to_radix_digits sitrd_checker u_sitrd_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_char_out(rsp_char_out),
   .rsp_last(rsp_last)
);
`default_nettype wire
